### design/vms_pkg.sv
package vms_pkg;

	localparam int MAX_VERSION_CHARS = 31;
	localparam int TAG_LETTERS       = 6;

	localparam int TAG_W  = 48;
	localparam int BYTE_W = 8;
	localparam int IDX_W  = 5;
	localparam int LEN_W  = 5;

	localparam logic [TAG_W-1:0] TAG_RESET = 48'h535157564552;

	// count holds up to MAX_VERSION_CHARS; store index addresses MAX_VERSION_CHARS entries
	localparam int CNT_W  = $clog2(MAX_VERSION_CHARS + 1);
	localparam int SIDX_W = $clog2(MAX_VERSION_CHARS);
	localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
	localparam int TSEL_W = (TAG_LETTERS > 1) ? $clog2(TAG_LETTERS) : 1;

	localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
	localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_LOW   = 8'h20;
	localparam logic [BYTE_W-1:0] CH_HIGH  = 8'h7E;
	localparam logic [BYTE_W-1:0] CH_V     = 8'h76;
	localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
	localparam logic [BYTE_W-1:0] CH_9     = 8'h39;

	typedef enum logic [1:0] {
		OP_SCAN  = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef struct packed {
		logic              found;
		logic              capturing;
		logic [LEN_W-1:0]  version_length;
		logic [BYTE_W-1:0] read_char;
	} result_t;

	// letter k sits at bit 8*(TAG_LETTERS-1-k); letters above the register read as zero
	function automatic logic [BYTE_W-1:0] tag_letter(input logic [TAG_W-1:0] tag,
			input logic [TSEL_W-1:0] k);
		logic [63:0] w;
		int          sh;
		w  = 64'(tag);
		sh = 8 * (TAG_LETTERS - 1 - int'(k));
		tag_letter = w[sh +: 8];
	endfunction

endpackage

### design/version_marker_scanner.sv
// Version marker scanner. Every transfer on the input stream gives exactly one result
// transfer. tuser selects the operation: scan a byte, clear the scan, or read one
// captured character. The block looks for the six tag letters held in tag_word (first
// letter in the top byte) followed by ':', then collects printable characters up to
// ';'; a non-empty capture starting with 'v' or a digit sets found, which holds and
// freezes the capture until a clear. Each result reports found, capturing, the
// current length and the read character. An item is held in the input register and
// its result is registered in the output register; one item is taken per cycle while
// the output is not stalled; the per-byte state update is the only loop. The user
// writes tag_word at APB address 0 only while the stream is idle; not enforced here.
module version_marker_scanner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // data_byte[7:0], read_index[12:8], zero[15:13]
	input  logic [1:0]  s_axis_tuser,  // op[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // found[0], capturing[1], version_length[6:2],
	                                   // read_char[14:7], zero[15]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	logic                         valid_s1;
	vms_pkg::op_t                 op_s1;
	logic [vms_pkg::BYTE_W-1:0]   byte_s1;
	logic [vms_pkg::IDX_W-1:0]    idx_s1;
	logic                         valid_s2;
	vms_pkg::result_t             result_s2;
	vms_pkg::result_t             result;
	logic                         step, in_xfer;
	logic [vms_pkg::TAG_W-1:0]    tag_word;
	logic                         found_st, taking_st;
	logic [vms_pkg::CNT_W-1:0]    count_st;

	vms_apb_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.tag_word (tag_word)
	);

	// item in s1 retires when the output register is empty or being drained
	assign step          = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || step;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1   <= vms_pkg::op_t'(s_axis_tuser);
			byte_s1 <= s_axis_tdata[7:0];
			idx_s1  <= s_axis_tdata[12:8];
		end
	end

	vms_scan_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.op         (op_s1),
		.data_byte  (byte_s1),
		.read_index (idx_s1),
		.tag_word   (tag_word),
		.result     (result),
		.found_st   (found_st),
		.taking_st  (taking_st),
		.count_st   (count_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {1'b0, result_s2.read_char, result_s2.version_length,
		result_s2.capturing, result_s2.found};

`ifndef SYNTHESIS
	a_found_not_capturing: assert property (@(posedge clk) disable iff (!arst_n)
		!(found_st && taking_st))
		else $error("found and capturing both set");

	a_tag_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(!found_st && !taking_st) |-> (count_st <= vms_pkg::CNT_W'(vms_pkg::TAG_LETTERS)))
		else $error("tag match count beyond tag length");

	a_clear_effect: assert property (@(posedge clk) disable iff (!arst_n)
		(step && op_s1 == vms_pkg::OP_CLEAR) |=> (!found_st && !taking_st && count_st == '0))
		else $error("clear did not reset scan state");

	a_found_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(found_st && !(step && op_s1 == vms_pkg::OP_CLEAR)) |=> found_st)
		else $error("found dropped without clear");
`endif

endmodule

### design/vms_apb_regs.sv
module vms_apb_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [3:0]                 paddr,
	input  logic [63:0]                pwdata,
	output logic [63:0]                prdata,
	output logic                       pready,
	output logic [vms_pkg::TAG_W-1:0]  tag_word
);

	localparam logic REG_TAG_WORD = 1'b0;

	logic [vms_pkg::TAG_W-1:0] tag_q;
	logic                      wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready && (paddr[3] == REG_TAG_WORD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= vms_pkg::TAG_RESET;
		end else if (wr_en) begin
			tag_q <= pwdata[vms_pkg::TAG_W-1:0];
		end
	end

	// byte lanes inside the 8-byte slot are ignored
	assign prdata   = (paddr[3] == REG_TAG_WORD) ? 64'(tag_q) : 64'd0;
	assign tag_word = tag_q;

endmodule

### design/vms_scan_core.sv
module vms_scan_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  vms_pkg::op_t                op,
	input  logic [vms_pkg::BYTE_W-1:0]  data_byte,
	input  logic [vms_pkg::IDX_W-1:0]   read_index,
	input  logic [vms_pkg::TAG_W-1:0]   tag_word,
	output vms_pkg::result_t            result,
	output logic                        found_st,
	output logic                        taking_st,
	output logic [vms_pkg::CNT_W-1:0]   count_st
);

	localparam int CNT_W  = vms_pkg::CNT_W;
	localparam int CMP_W  = vms_pkg::CMP_W;
	localparam int SIDX_W = vms_pkg::SIDX_W;

	logic [CNT_W-1:0]          mc_q, mc_d;
	logic                      taking_q, taking_d;
	logic                      found_q, found_d;
	logic [vms_pkg::BYTE_W-1:0] store_q [vms_pkg::MAX_VERSION_CHARS];

	logic [vms_pkg::BYTE_W-1:0] letter0, cur_letter, first_char, rd_data;
	logic [CNT_W-1:0]          restart;
	logic                      printable, first_ok, wr_en, rd_ok;
	logic [CMP_W-1:0]          rd_ext;
	logic [SIDX_W-1:0]         rd_addr;

	assign letter0    = vms_pkg::tag_letter(tag_word, '0);
	assign cur_letter = (mc_q < CNT_W'(vms_pkg::TAG_LETTERS)) ?
		vms_pkg::tag_letter(tag_word, vms_pkg::TSEL_W'(mc_q)) : '0;
	assign restart    = CNT_W'(data_byte == letter0);
	assign printable  = (data_byte >= vms_pkg::CH_LOW) && (data_byte <= vms_pkg::CH_HIGH);
	assign first_char = store_q[0];
	assign first_ok   = first_char inside {vms_pkg::CH_V, [vms_pkg::CH_0:vms_pkg::CH_9]};

	always_comb begin
		mc_d     = mc_q;
		taking_d = taking_q;
		found_d  = found_q;
		wr_en    = 1'b0;
		case (op)
			vms_pkg::OP_SCAN: begin
				if (!found_q) begin
					if (taking_q) begin
						if (data_byte == vms_pkg::CH_SEMI) begin
							taking_d = 1'b0;
							if (mc_q != '0 && first_ok) begin
								found_d = 1'b1;
							end else begin
								mc_d = '0;
							end
						end else if (!printable ||
								mc_q >= CNT_W'(vms_pkg::MAX_VERSION_CHARS)) begin
							taking_d = 1'b0;
							mc_d     = restart;
						end else begin
							wr_en = 1'b1;
							mc_d  = mc_q + CNT_W'(1);
						end
					end else if (mc_q >= CNT_W'(vms_pkg::TAG_LETTERS)) begin
						if (data_byte == vms_pkg::CH_COLON) begin
							mc_d     = '0;
							taking_d = 1'b1;
						end else begin
							mc_d = restart;
						end
					end else if (data_byte == cur_letter) begin
						mc_d = mc_q + CNT_W'(1);
					end else begin
						mc_d = restart;
					end
				end
			end
			vms_pkg::OP_CLEAR: begin
				mc_d     = '0;
				taking_d = 1'b0;
				found_d  = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mc_q     <= '0;
			taking_q <= 1'b0;
			found_q  <= 1'b0;
		end else if (step) begin
			mc_q     <= mc_d;
			taking_q <= taking_d;
			found_q  <= found_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && wr_en) begin
			store_q[mc_q[SIDX_W-1:0]] <= data_byte;
		end
	end

	assign rd_ext  = CMP_W'(read_index);
	assign rd_addr = rd_ext[SIDX_W-1:0];
	assign rd_ok   = (op == vms_pkg::OP_READ) && (taking_q || found_q) &&
		(rd_ext < CMP_W'(mc_q)) && (rd_ext < CMP_W'(vms_pkg::MAX_VERSION_CHARS));
	assign rd_data = rd_ok ? store_q[rd_addr] : '0;

	assign result.found          = found_d;
	assign result.capturing      = taking_d;
	assign result.version_length = vms_pkg::LEN_W'(mc_d);
	assign result.read_char      = rd_data;

	assign found_st  = found_q;
	assign taking_st = taking_q;
	assign count_st  = mc_q;

endmodule
